[hw/rtl/vnps_pkg.sv]
`default_nettype none

package vnps_pkg;

    // Field and register widths
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int GAIN_W    = 16;
    localparam int COMP_W    = 16;
    localparam int DIR_W     = 3 * COMP_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = DIR_W;
    localparam int COLOUR_W  = 16;

    // Datapath widths
    localparam int SUM_W     = 42;
    localparam int CROSS_W   = 35;
    localparam int MUL_W     = 35;
    localparam int ACC_W     = 2 * MUL_W;
    localparam int MAG_KEEP  = 24;
    localparam int MM_W      = 50;
    localparam int DOT_W     = 42;
    localparam int VL_W      = 34;
    localparam int NRM_W     = 25;
    localparam int Q_W       = 18;
    localparam int REM_W     = NRM_W + Q_W - 1;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int BASE_W    = 36;
    localparam int FRAC_PW   = 28;
    localparam int EXP_BIT_W = 4;
    localparam int TOTAL_W   = COLOUR_W + 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT    = 3'd5;

    typedef enum logic {
        IT_SQRT = 1'b0,
        IT_DIV  = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic                 start;
        t_iter_op             op;
        logic [RAD_W-1:0]     rad;
        logic [REM_W-1:0]     num;
        logic [NRM_W-1:0]     den;
    } t_iter_req;

    typedef struct packed {
        logic                 done;
        logic [ROOT_W-1:0]    res;
    } t_iter_rsp;

endpackage

`default_nettype wire

[hw/rtl/vnps_if.sv]
`default_nettype none

interface vnps_corner_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vnps_pkg::COORD_W-1:0]  cur_x;
    logic signed [vnps_pkg::COORD_W-1:0]  cur_y;
    logic signed [vnps_pkg::COORD_W-1:0]  cur_z;
    logic signed [vnps_pkg::COORD_W-1:0]  prev_x;
    logic signed [vnps_pkg::COORD_W-1:0]  prev_y;
    logic signed [vnps_pkg::COORD_W-1:0]  prev_z;
    logic signed [vnps_pkg::COORD_W-1:0]  next_x;
    logic signed [vnps_pkg::COORD_W-1:0]  next_y;
    logic signed [vnps_pkg::COORD_W-1:0]  next_z;
    logic                                 last_corner;

    modport source (output valid, cur_x, cur_y, cur_z, prev_x, prev_y, prev_z,
                    next_x, next_y, next_z, last_corner, input ready);
    modport sink   (input valid, cur_x, cur_y, cur_z, prev_x, prev_y, prev_z,
                    next_x, next_y, next_z, last_corner, output ready);
endinterface

interface vnps_shade_if;
    logic                          valid;
    logic                          ready;
    logic [vnps_pkg::COLOUR_W-1:0] colour;

    modport source (output valid, colour, input ready);
    modport sink   (input valid, colour, output ready);
endinterface

interface vnps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vnps_pkg::CFG_IDX_W-1:0] index;
    logic [vnps_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/vnps_iter.sv]
`default_nettype none

// Shared iterative unit: floor square root, one result bit a cycle, or
// unsigned restoring division, one quotient bit a cycle.
module vnps_iter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vnps_pkg::t_iter_req i_req,
    output vnps_pkg::t_iter_rsp o_rsp
);
    import vnps_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    typedef enum logic [2:0] {
        IS_IDLE = 3'b001,
        IS_SQRT = 3'b010,
        IS_DIV  = 3'b100
    } t_istate;

    t_istate           r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [REM_W-1:0]  r_dsh, n_dsh;
    logic              r_done, n_done;
    logic [REM_W-1:0]  sq_sh, sq_trial;

    assign sq_sh    = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_rad   = r_rad;
        n_root  = r_root;
        n_dsh   = r_dsh;
        n_done  = 1'b0;
        case (r_state)
            IS_IDLE: begin
                if (i_req.start) begin
                    n_rad  = i_req.rad;
                    n_root = '0;
                    n_dsh  = {i_req.den, {(Q_W-1){1'b0}}};
                    if (i_req.op == IT_SQRT) begin
                        n_rem   = '0;
                        n_cnt   = CNT_W'(ROOT_W - 1);
                        n_state = IS_SQRT;
                    end else begin
                        n_rem   = i_req.num;
                        n_cnt   = CNT_W'(Q_W - 1);
                        n_state = IS_DIV;
                    end
                end
            end
            IS_SQRT: begin
                n_rad = {r_rad[RAD_W-3:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    n_rem  = sq_sh - sq_trial;
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = sq_sh;
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = IS_IDLE;
                end
            end
            IS_DIV: begin
                if (r_rem >= r_dsh) begin
                    n_rem  = r_rem - r_dsh;
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = IS_IDLE;
                end
            end
            default: n_state = IS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_rad  <= n_rad;
        r_root <= n_root;
        r_dsh  <= n_dsh;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_root;

endmodule

`default_nettype wire

[hw/rtl/vertex_normal_phong_shader_top.sv]
`default_nettype none
// A corner without the last mark is added to the sums, and the block is then ready again.
// A last corner also goes through normalization, dot products, a root and the divisions,
// plus 8 square roots and the power loop when the specular base and exponent are nonzero.
// A corner is taken only when idle: one shared multiplier and one shared root/divide
// unit do all the work. Reset is synchronous, active low: clears sums and restores registers.
module vertex_normal_phong_shader_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vnps_corner_if.sink   i_corner,
    vnps_shade_if.source  o_shade,
    vnps_cfg_if.sink      i_cfg
);
    import vnps_pkg::*;

    // Sequencer states
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_ACC   = 13'b0000000000010,
        ST_MAG   = 13'b0000000000100,
        ST_NORM  = 13'b0000000001000,
        ST_DOTS  = 13'b0000000010000,
        ST_NRM   = 13'b0000000100000,
        ST_DIVL  = 13'b0000001000000,
        ST_DIVV  = 13'b0000010000000,
        ST_SPEC  = 13'b0000100000000,
        ST_POW   = 13'b0001000000000,
        ST_ROOT  = 13'b0010000000000,
        ST_PWR   = 13'b0100000000000,
        ST_FINAL = 13'b1000000000000
    } t_state;

    // What the shared multiply-accumulate does this cycle
    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    localparam logic [ROOT_W-1:0]   ONE_PW    = ROOT_W'(1) << FRAC_PW;
    localparam logic [COLOUR_W-1:0] TERM_ONE  = COLOUR_W'(4096);
    localparam logic [COLOUR_W-1:0] COLOUR_SAT = '1;

    // Configuration registers
    logic [GAIN_W-1:0] r_ambient, r_diffuse, r_specular, r_spread;
    logic [DIR_W-1:0]  r_view, r_light;

    // Sequencer and datapath registers
    t_state                    r_state, n_state;
    logic [3:0]                r_cnt, n_cnt;
    logic                      r_wait, n_wait;
    logic signed [DIFF_W-1:0]  r_a [3];
    logic signed [DIFF_W-1:0]  r_b [3];
    logic                      r_last;
    logic signed [CROSS_W-1:0] r_n [3];
    logic signed [CROSS_W-1:0] n_n [3];
    logic [SUM_W-1:0]          r_sum [3];
    logic [SUM_W-1:0]          n_sum [3];
    logic [SUM_W-1:0]          r_mag [3];
    logic [SUM_W-1:0]          n_mag [3];
    logic [2:0]                r_neg, n_neg;
    logic [SUM_W-1:0]          r_mx, n_mx;
    logic signed [ACC_W-1:0]   r_mac, n_mac;
    logic [MM_W-1:0]           r_mm, n_mm;
    logic signed [DOT_W-1:0]   r_lm, n_lm, r_vm, n_vm;
    logic signed [VL_W-1:0]    r_vl, n_vl;
    logic [NRM_W-1:0]          r_nrm, n_nrm;
    logic signed [Q_W-1:0]     r_ln, n_ln, r_vn, n_vn;
    logic [MUL_W-1:0]          r_rv, n_rv;
    logic [Q_W-1:0]            r_diff, n_diff;
    logic [BASE_W-1:0]         r_x, n_x;
    logic [ROOT_W-1:0]         r_acc, n_acc;
    logic [EXP_BIT_W-1:0]      r_bit, n_bit;
    logic [2:0]                r_rounds, n_rounds;
    logic [COLOUR_W-1:0]       r_term, n_term;
    logic                      r_ovalid, n_ovalid;
    logic [COLOUR_W-1:0]       r_colour, n_colour;

    // Combinational helpers
    t_mac_op                   mac_op;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]   prod;
    logic signed [MUL_W-1:0]   m_op [3];
    logic [SUM_W-1:0]          abs_s [3];
    logic [TOTAL_W-1:0]        total;
    logic [REM_W-1:0]          div_num;
    logic                      div_neg;
    logic signed [Q_W-1:0]     quot;
    t_iter_req                 iter_req;
    t_iter_rsp                 iter_rsp;

    function automatic logic signed [COMP_W-1:0] dcomp(input logic [DIR_W-1:0] v,
                                                       input int idx);
        return v[idx*COMP_W +: COMP_W];
    endfunction

    vnps_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    assign prod  = mul_a * mul_b;
    assign total = TOTAL_W'(r_ambient) + TOTAL_W'(r_diff) + TOTAL_W'(r_term);

    // Signed normalized normal components and magnitudes of the running sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_op[i]  = MUL_W'(r_mag[i][MAG_KEEP-1:0]);
            if (r_neg[i]) begin
                m_op[i] = -m_op[i];
            end
            abs_s[i] = r_sum[i][SUM_W-1] ? (SUM_W'(0) - r_sum[i]) : r_sum[i];
        end
    end

    // Divider operands: magnitude of L.M or V.M, sign applied to the quotient
    always_comb begin
        if (r_state == ST_DIVL) begin
            div_neg = r_lm[DOT_W-1];
            div_num = div_neg ? REM_W'(-r_lm) : REM_W'(r_lm);
        end else begin
            div_neg = r_vm[DOT_W-1];
            div_num = div_neg ? REM_W'(-r_vm) : REM_W'(r_vm);
        end
        quot = Q_W'(iter_rsp.res);
        if (div_neg) begin
            quot = -quot;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_wait   = r_wait;
        n_n      = r_n;
        n_sum    = r_sum;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_mx     = r_mx;
        n_mm     = r_mm;
        n_lm     = r_lm;
        n_vm     = r_vm;
        n_vl     = r_vl;
        n_nrm    = r_nrm;
        n_ln     = r_ln;
        n_vn     = r_vn;
        n_rv     = r_rv;
        n_diff   = r_diff;
        n_x      = r_x;
        n_acc    = r_acc;
        n_bit    = r_bit;
        n_rounds = r_rounds;
        n_term   = r_term;
        n_colour = r_colour;
        n_ovalid = r_ovalid && !o_shade.ready;
        mac_op   = MAC_HOLD;
        mul_a    = '0;
        mul_b    = '0;
        iter_req = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_corner.valid) begin
                    n_cnt   = '0;
                    n_state = ST_ACC;
                end
            end

            // Cross product of the edge vectors, its sign against the view, then the running sums
            ST_ACC: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt)
                    4'd0: begin
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_a[1]); mul_b = MUL_W'(r_b[2]);
                    end
                    4'd1: begin
                        mac_op = MAC_SUB;  mul_a = MUL_W'(r_a[2]); mul_b = MUL_W'(r_b[1]);
                    end
                    4'd2: begin
                        n_n[0] = r_mac[CROSS_W-1:0];
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_a[2]); mul_b = MUL_W'(r_b[0]);
                    end
                    4'd3: begin
                        mac_op = MAC_SUB;  mul_a = MUL_W'(r_a[0]); mul_b = MUL_W'(r_b[2]);
                    end
                    4'd4: begin
                        n_n[1] = r_mac[CROSS_W-1:0];
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_a[0]); mul_b = MUL_W'(r_b[1]);
                    end
                    4'd5: begin
                        mac_op = MAC_SUB;  mul_a = MUL_W'(r_a[1]); mul_b = MUL_W'(r_b[0]);
                    end
                    4'd6: begin
                        n_n[2] = r_mac[CROSS_W-1:0];
                        mac_op = MAC_LOAD; mul_a = r_n[0]; mul_b = MUL_W'(dcomp(r_view, 0));
                    end
                    4'd7: begin
                        mac_op = MAC_ADD;  mul_a = r_n[1]; mul_b = MUL_W'(dcomp(r_view, 1));
                    end
                    4'd8: begin
                        mac_op = MAC_ADD;  mul_a = r_n[2]; mul_b = MUL_W'(dcomp(r_view, 2));
                    end
                    default: begin
                        // Flip the corner normal when it faces away from the viewer
                        for (int i = 0; i < 3; i++) begin
                            if (r_mac[ACC_W-1]) begin
                                n_sum[i] = r_sum[i] - SUM_W'(r_n[i]);
                            end else begin
                                n_sum[i] = r_sum[i] + SUM_W'(r_n[i]);
                            end
                        end
                        n_state = r_last ? ST_MAG : ST_IDLE;
                    end
                endcase
            end

            // Latch magnitudes and signs, clear the sums for the next vertex
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    n_mag[i] = abs_s[i];
                    n_neg[i] = r_sum[i][SUM_W-1];
                    n_sum[i] = '0;
                end
                n_mx = abs_s[0];
                if (abs_s[1] > n_mx) begin
                    n_mx = abs_s[1];
                end
                if (abs_s[2] > n_mx) begin
                    n_mx = abs_s[2];
                end
                if (n_mx == '0) begin
                    // Zero normal: no lighting from L.N
                    n_diff  = '0;
                    n_x     = '0;
                    n_state = ST_POW;
                end else begin
                    n_state = ST_NORM;
                end
            end

            // Shift one bit a cycle until the largest magnitude is in [2^23, 2^24)
            ST_NORM: begin
                if (|r_mx[SUM_W-1:MAG_KEEP]) begin
                    for (int i = 0; i < 3; i++) begin
                        n_mag[i] = r_mag[i] >> 1;
                    end
                    n_mx = r_mx >> 1;
                end else if (!r_mx[MAG_KEEP-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        n_mag[i] = r_mag[i] << 1;
                    end
                    n_mx = r_mx << 1;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_DOTS;
                end
            end

            // M.M, L.M, V.M and V.L on the shared multiplier
            ST_DOTS: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt)
                    4'd0: begin mac_op = MAC_LOAD; mul_a = m_op[0]; mul_b = m_op[0]; end
                    4'd1: begin mac_op = MAC_ADD;  mul_a = m_op[1]; mul_b = m_op[1]; end
                    4'd2: begin mac_op = MAC_ADD;  mul_a = m_op[2]; mul_b = m_op[2]; end
                    4'd3: begin
                        n_mm   = r_mac[MM_W-1:0];
                        mac_op = MAC_LOAD; mul_a = MUL_W'(dcomp(r_light, 0)); mul_b = m_op[0];
                    end
                    4'd4: begin
                        mac_op = MAC_ADD;  mul_a = MUL_W'(dcomp(r_light, 1)); mul_b = m_op[1];
                    end
                    4'd5: begin
                        mac_op = MAC_ADD;  mul_a = MUL_W'(dcomp(r_light, 2)); mul_b = m_op[2];
                    end
                    4'd6: begin
                        n_lm   = r_mac[DOT_W-1:0];
                        mac_op = MAC_LOAD; mul_a = MUL_W'(dcomp(r_view, 0)); mul_b = m_op[0];
                    end
                    4'd7: begin
                        mac_op = MAC_ADD;  mul_a = MUL_W'(dcomp(r_view, 1)); mul_b = m_op[1];
                    end
                    4'd8: begin
                        mac_op = MAC_ADD;  mul_a = MUL_W'(dcomp(r_view, 2)); mul_b = m_op[2];
                    end
                    4'd9: begin
                        n_vm   = r_mac[DOT_W-1:0];
                        mac_op = MAC_LOAD;
                        mul_a  = MUL_W'(dcomp(r_view, 0));
                        mul_b  = MUL_W'(dcomp(r_light, 0));
                    end
                    4'd10: begin
                        mac_op = MAC_ADD;
                        mul_a  = MUL_W'(dcomp(r_view, 1));
                        mul_b  = MUL_W'(dcomp(r_light, 1));
                    end
                    4'd11: begin
                        mac_op = MAC_ADD;
                        mul_a  = MUL_W'(dcomp(r_view, 2));
                        mul_b  = MUL_W'(dcomp(r_light, 2));
                    end
                    default: begin
                        n_vl    = r_mac[VL_W-1:0];
                        n_wait  = 1'b0;
                        n_state = ST_NRM;
                    end
                endcase
            end

            // Length of M
            ST_NRM: begin
                iter_req.op  = IT_SQRT;
                iter_req.rad = RAD_W'(r_mm);
                if (!r_wait) begin
                    iter_req.start = 1'b1;
                    n_wait         = 1'b1;
                end else if (iter_rsp.done) begin
                    n_nrm   = iter_rsp.res[NRM_W-1:0];
                    n_wait  = 1'b0;
                    n_state = ST_DIVL;
                end
            end

            // L.N and V.N, truncated toward zero
            ST_DIVL, ST_DIVV: begin
                iter_req.op  = IT_DIV;
                iter_req.num = div_num;
                iter_req.den = r_nrm;
                if (!r_wait) begin
                    iter_req.start = 1'b1;
                    n_wait         = 1'b1;
                end else if (iter_rsp.done) begin
                    n_wait = 1'b0;
                    if (r_state == ST_DIVL) begin
                        n_ln    = quot;
                        n_state = ST_DIVV;
                    end else begin
                        n_vn = quot;
                        if (!r_ln[Q_W-1] && r_ln != '0) begin
                            n_cnt   = '0;
                            n_state = ST_SPEC;
                        end else begin
                            n_diff  = '0;
                            n_x     = '0;
                            n_state = ST_POW;
                        end
                    end
                end
            end

            // Reflection term, diffuse term and specular base
            ST_SPEC: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt)
                    4'd0: begin
                        mac_op = MAC_LOAD;
                        mul_a  = MUL_W'(r_vn) <<< 1;
                        mul_b  = MUL_W'(r_ln);
                    end
                    4'd1: begin
                        mac_op = MAC_SUB; mul_a = MUL_W'(r_vl); mul_b = MUL_W'(1);
                    end
                    4'd2: begin
                        n_rv   = (!r_mac[ACC_W-1] && r_mac != '0) ? r_mac[MUL_W-1:0] : '0;
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_diffuse); mul_b = MUL_W'(r_ln);
                    end
                    4'd3: begin
                        n_diff = r_mac[Q_W+14:15];
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_specular); mul_b = r_rv;
                    end
                    default: begin
                        if (|r_mac[ACC_W-1:BASE_W+14]) begin
                            n_x = '1;
                        end else begin
                            n_x = r_mac[BASE_W+13:14];
                        end
                        n_state = ST_POW;
                    end
                endcase
            end

            // Exponent zero gives one, a zero base gives zero
            ST_POW: begin
                if (r_spread == '0) begin
                    n_term  = TERM_ONE;
                    n_state = ST_FINAL;
                end else if (r_x == '0) begin
                    n_term  = '0;
                    n_state = ST_FINAL;
                end else begin
                    n_rounds = '0;
                    n_wait   = 1'b0;
                    n_state  = ST_ROOT;
                end
            end

            // Eight square roots turn the Q8.8 exponent into an integer one
            ST_ROOT: begin
                iter_req.op  = IT_SQRT;
                iter_req.rad = {r_x, {FRAC_PW{1'b0}}};
                if (!r_wait) begin
                    iter_req.start = 1'b1;
                    n_wait         = 1'b1;
                end else if (iter_rsp.done) begin
                    n_x      = BASE_W'(iter_rsp.res);
                    n_wait   = 1'b0;
                    n_rounds = r_rounds + 1'b1;
                    if (r_rounds == 3'd7) begin
                        n_acc   = ONE_PW;
                        n_bit   = '1;
                        n_cnt   = '0;
                        n_state = ST_PWR;
                    end
                end
            end

            // Square-and-multiply from the top exponent bit, saturate at 16.0
            ST_PWR: begin
                case (r_cnt)
                    4'd0: begin
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_acc); mul_b = MUL_W'(r_acc);
                        n_cnt  = 4'd1;
                    end
                    4'd2: begin
                        mac_op = MAC_LOAD; mul_a = MUL_W'(r_acc); mul_b = MUL_W'(r_x);
                        n_cnt  = 4'd3;
                    end
                    default: begin
                        if (|r_mac[ACC_W-1:ROOT_W+FRAC_PW]) begin
                            n_term  = COLOUR_SAT;
                            n_state = ST_FINAL;
                        end else begin
                            n_acc = r_mac[ROOT_W+FRAC_PW-1:FRAC_PW];
                            if (r_cnt == 4'd1 && r_spread[r_bit]) begin
                                n_cnt = 4'd2;
                            end else if (r_bit == '0) begin
                                n_term  = n_acc[ROOT_W-1 -: COLOUR_W];
                                n_state = ST_FINAL;
                            end else begin
                                n_bit = r_bit - 1'b1;
                                n_cnt = '0;
                            end
                        end
                    end
                endcase
            end

            // Sum, saturate and load the output register once it is free
            ST_FINAL: begin
                if (!r_ovalid || o_shade.ready) begin
                    n_colour = (|total[TOTAL_W-1:COLOUR_W]) ? COLOUR_SAT
                                                            : total[COLOUR_W-1:0];
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        case (mac_op)
            MAC_LOAD: n_mac = prod;
            MAC_ADD:  n_mac = r_mac + prod;
            MAC_SUB:  n_mac = r_mac - prod;
            default:  n_mac = r_mac;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
            r_sum    <= n_sum;
        end
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_mx     <= n_mx;
        r_mac    <= n_mac;
        r_mm     <= n_mm;
        r_lm     <= n_lm;
        r_vm     <= n_vm;
        r_vl     <= n_vl;
        r_nrm    <= n_nrm;
        r_ln     <= n_ln;
        r_vn     <= n_vn;
        r_rv     <= n_rv;
        r_diff   <= n_diff;
        r_x      <= n_x;
        r_acc    <= n_acc;
        r_bit    <= n_bit;
        r_rounds <= n_rounds;
        r_term   <= n_term;
        r_colour <= n_colour;
    end

    // Capture edge vectors of an accepted corner
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_corner.valid) begin
            r_a[0] <= DIFF_W'(i_corner.cur_x) - DIFF_W'(i_corner.prev_x);
            r_a[1] <= DIFF_W'(i_corner.cur_y) - DIFF_W'(i_corner.prev_y);
            r_a[2] <= DIFF_W'(i_corner.cur_z) - DIFF_W'(i_corner.prev_z);
            r_b[0] <= DIFF_W'(i_corner.cur_x) - DIFF_W'(i_corner.next_x);
            r_b[1] <= DIFF_W'(i_corner.cur_y) - DIFF_W'(i_corner.next_y);
            r_b[2] <= DIFF_W'(i_corner.cur_z) - DIFF_W'(i_corner.next_z);
            r_last <= i_corner.last_corner;
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient  <= '0;
            r_diffuse  <= GAIN_W'(4096);
            r_specular <= '0;
            r_spread   <= GAIN_W'(256);
            r_view     <= '0;
            r_light    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_AMBIENT:  r_ambient  <= i_cfg.data[GAIN_W-1:0];
                CFG_DIFFUSE:  r_diffuse  <= i_cfg.data[GAIN_W-1:0];
                CFG_SPECULAR: r_specular <= i_cfg.data[GAIN_W-1:0];
                CFG_SPREAD:   r_spread   <= i_cfg.data[GAIN_W-1:0];
                CFG_VIEW:     r_view     <= i_cfg.data[DIR_W-1:0];
                CFG_LIGHT:    r_light    <= i_cfg.data[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_corner.ready = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_shade.valid  = r_ovalid;
    assign o_shade.colour = r_colour;

endmodule

`default_nettype wire

[hw/rtl/vnps_check.sv]
`default_nettype none

module vnps_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [vnps_pkg::COLOUR_W-1:0] i_colour
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_colour))
        else $error("result changed while stalled");

    // An accepted corner keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while busy");

    // No result appears right after an accepted corner
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result produced too early");

endmodule

bind vertex_normal_phong_shader_top vnps_check u_vnps_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_corner.valid),
    .i_in_ready  (i_corner.ready),
    .i_out_valid (o_shade.valid),
    .i_out_ready (o_shade.ready),
    .i_colour    (o_shade.colour)
);

`default_nettype wire

[verif/vertex_normal_phong_shader_top_test.sv]
`default_nettype none

module vertex_normal_phong_shader_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vnps_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] cur_x, cur_y, cur_z;
        logic signed [COORD_W-1:0] prev_x, prev_y, prev_z;
        logic signed [COORD_W-1:0] next_x, next_y, next_z;
        logic                      last_corner;
    } corner_t;

    localparam int PAUSE_CYCLES = 700;   // worst last-corner latency with margin
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int STUCK_LIMIT  = 6000;  // cycles with no handshake at all

    logic i_clk;
    logic i_rst_n;

    vnps_corner_if corner_ch();
    vnps_shade_if  shade_ch();
    vnps_cfg_if    cfg_ch();

    vertex_normal_phong_shader_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_corner (corner_ch.sink),
        .o_shade  (shade_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    // Clock: 10 ns period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shading state mirrored in the testbench
    logic [GAIN_W-1:0] amb_gain, dif_gain, spec_gain, spread;
    logic [DIR_W-1:0]  view_vec, light_vec;
    logic [SUM_W-1:0]  nsum [3];

    corner_t          corner_q [$];   // corners waiting for the driver
    logic [COLOUR_W-1:0] colour_q [$]; // colours still due from the block

    int  mismatches;
    bit  calm;           // no idling in the last part of the run
    bit  hold_due;       // ask the receiver for one long hold-off
    bit  corner_took;
    int  stuck_cycles;

    function automatic longint dir_comp(logic [DIR_W-1:0] v, int i);
        return longint'($signed(v[COMP_W*i +: COMP_W]));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root, bt;
        root = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= root + bt) begin
                v = v - (root + bt);
                root = (root >> 1) + bt;
            end else begin
                root = root >> 1;
            end
            bt = bt >> 2;
        end
        return root;
    endfunction

    // Specular power in Q.28: eight roots, then square-and-multiply on the exponent
    function automatic logic [63:0] spec_power(logic [63:0] base, logic [15:0] e);
        logic [63:0] x, acc;
        if (e == 0) return 64'd4096;
        if (base == 0) return 64'd0;
        x = base;
        acc = 64'd1 << 28;
        for (int i = 0; i < 8; i++) x = int_sqrt(x << 28);
        for (int i = 15; i >= 0; i--) begin
            acc = (acc * acc) >> 28;
            if (acc >= (64'd1 << 32)) return 64'd65535;
            if (e[i]) begin
                acc = (acc * x) >> 28;
                if (acc >= (64'd1 << 32)) return 64'd65535;
            end
        end
        return acc >> 16;
    endfunction

    function automatic logic [COLOUR_W-1:0] vertex_colour();
        longint s [3], m [3], mag [3];
        longint mx, lm, vm, nrm, ln, vn, vl, r;
        logic [63:0] diffuse, base, term, total;
        int up, dn;
        mx = 0; lm = 0; vm = 0; ln = 0; vn = 0; vl = 0; diffuse = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = longint'($signed(nsum[i]));
            mag[i] = s[i] < 0 ? -s[i] : s[i];
            if (mag[i] > mx) mx = mag[i];
            vl += dir_comp(view_vec, i) * dir_comp(light_vec, i);
        end
        if (mx != 0) begin
            up = 0; dn = 0;
            while ((mx >> dn) >= (64'sd1 << 24)) dn++;
            while ((mx << up) < (64'sd1 << 23)) up++;
            for (int i = 0; i < 3; i++) begin
                m[i] = (mag[i] >> dn) << up;
                if (s[i] < 0) m[i] = -m[i];
                lm += dir_comp(light_vec, i) * m[i];
                vm += dir_comp(view_vec, i) * m[i];
            end
            nrm = longint'(int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]));
            ln = lm / nrm;
            vn = vm / nrm;
        end
        if (ln > 0) begin
            r = 2 * vn * ln - vl;
            base = 0;
            diffuse = (64'(dif_gain) * 64'(ln)) >> 15;
            if (r > 0) begin
                base = (64'(spec_gain) * 64'(r)) >> 14;
                if (base > (64'd1 << 36) - 1) base = (64'd1 << 36) - 1;
            end
            term = spec_power(base, spread);
        end else begin
            term = spec_power(0, spread);
        end
        total = 64'(amb_gain) + diffuse + term;
        return total > 64'd65535 ? 16'hFFFF : total[15:0];
    endfunction

    // Fold one corner into the running normal; queue a colour on a last corner
    function automatic void shade_corner(corner_t c);
        longint cp [3], pp [3], np [3], ea [3], eb [3], n [3], dot;
        cp = '{c.cur_x, c.cur_y, c.cur_z};
        pp = '{c.prev_x, c.prev_y, c.prev_z};
        np = '{c.next_x, c.next_y, c.next_z};
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            ea[i] = cp[i] - pp[i];
            eb[i] = cp[i] - np[i];
        end
        n[0] = ea[1] * eb[2] - ea[2] * eb[1];
        n[1] = ea[2] * eb[0] - ea[0] * eb[2];
        n[2] = ea[0] * eb[1] - ea[1] * eb[0];
        for (int i = 0; i < 3; i++) dot += n[i] * dir_comp(view_vec, i);
        for (int i = 0; i < 3; i++) begin
            if (dot < 0) nsum[i] = nsum[i] - n[i][SUM_W-1:0];
            else         nsum[i] = nsum[i] + n[i][SUM_W-1:0];
        end
        if (c.last_corner) begin
            colour_q.push_back(vertex_colour());
            for (int i = 0; i < 3; i++) nsum[i] = '0;
        end
    endfunction

    // Corner driver: change at the falling edge, hold until taken
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            corner_ch.valid <= 1'b0;
            send_gap = 0;
        end else if (!(corner_ch.valid && !corner_took)) begin
            if (send_gap > 0) begin
                send_gap--;
                corner_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(1, 12);
                corner_ch.valid <= 1'b0;
            end else if (corner_q.size() > 0) begin
                corner_t c;
                c = corner_q.pop_front();
                {corner_ch.cur_x, corner_ch.cur_y, corner_ch.cur_z,
                 corner_ch.prev_x, corner_ch.prev_y, corner_ch.prev_z,
                 corner_ch.next_x, corner_ch.next_y, corner_ch.next_z,
                 corner_ch.last_corner} <= c;
                corner_ch.valid <= 1'b1;
            end else begin
                corner_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    int stall_left;
    bit hold_done;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            shade_ch.ready <= 1'b0;
            stall_left = 0;
            hold_done = 0;
        end else begin
            if (hold_due && !hold_done) begin
                hold_done = 1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                stall_left--;
                shade_ch.ready <= 1'b0;
            end else begin
                shade_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on every accepted corner, check every accepted colour
    always @(posedge i_clk) begin
        corner_took <= corner_ch.valid && corner_ch.ready;
        if (i_rst_n) begin
            if (corner_ch.valid && corner_ch.ready) begin
                shade_corner({corner_ch.cur_x, corner_ch.cur_y, corner_ch.cur_z,
                              corner_ch.prev_x, corner_ch.prev_y, corner_ch.prev_z,
                              corner_ch.next_x, corner_ch.next_y, corner_ch.next_z,
                              corner_ch.last_corner});
            end
            if (shade_ch.valid && shade_ch.ready) begin
                if (colour_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected colour %0d", shade_ch.colour);
                end else begin
                    logic [COLOUR_W-1:0] want;
                    want = colour_q.pop_front();
                    if (shade_ch.colour !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("colour mismatch: expected %0d got %0d",
                                     want, shade_ch.colour);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((corner_ch.valid && corner_ch.ready) || (shade_ch.valid && shade_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_AMBIENT:  amb_gain  = val[GAIN_W-1:0];
            CFG_DIFFUSE:  dif_gain  = val[GAIN_W-1:0];
            CFG_SPECULAR: spec_gain = val[GAIN_W-1:0];
            CFG_SPREAD:   spread    = val[GAIN_W-1:0];
            CFG_VIEW:     view_vec  = val;
            CFG_LIGHT:    light_vec = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain: wait for all corners and colours, then for the tail latency
    task automatic drain();
        while (corner_q.size() > 0 || corner_ch.valid || colour_q.size() > 0)
            @(posedge i_clk);
        repeat (PAUSE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_corner(logic signed [COORD_W-1:0] cx, cy, cz, px, py, pz,
                              nx, ny, nz, logic last);
        corner_q.push_back({cx, cy, cz, px, py, pz, nx, ny, nz, last});
    endtask

    // Random unit-ish direction; occasionally fully random bits
    function automatic logic [DIR_W-1:0] rand_dir();
        logic [DIR_W-1:0] d;
        if ($urandom_range(0, 4) == 0) return {$urandom(), $urandom()};
        for (int i = 0; i < 3; i++)
            d[COMP_W*i +: COMP_W] = 16'($signed($urandom_range(0, 36000)) - 18000);
        return d;
    endfunction

    // Corners around one vertex: neighbours near cur, random content
    task automatic add_group(int corners, int reach, bit mark_last);
        logic signed [COORD_W-1:0] cx, cy, cz;
        cx = $urandom(); cy = $urandom(); cz = $urandom();
        for (int k = 0; k < corners; k++) begin
            add_corner(cx, cy, cz,
                       cx + 16'($signed($urandom_range(0, 2 * reach)) - reach),
                       cy + 16'($signed($urandom_range(0, 2 * reach)) - reach),
                       cz + 16'($signed($urandom_range(0, 2 * reach)) - reach),
                       cx + 16'($signed($urandom_range(0, 2 * reach)) - reach),
                       cy + 16'($signed($urandom_range(0, 2 * reach)) - reach),
                       cz + 16'($signed($urandom_range(0, 2 * reach)) - reach),
                       mark_last && (k == corners - 1));
        end
    endtask

    initial begin
        logic [GAIN_W-1:0] sp;
        int reach;
        mismatches = 0;
        calm = 0;
        hold_due = 0;
        stuck_cycles = 0;
        amb_gain = 0; dif_gain = 16'd4096; spec_gain = 0; spread = 16'd256;
        view_vec = '0; light_vec = '0;
        for (int i = 0; i < 3; i++) nsum[i] = '0;
        corner_ch.valid = 1'b0;
        {corner_ch.cur_x, corner_ch.cur_y, corner_ch.cur_z, corner_ch.prev_x,
         corner_ch.prev_y, corner_ch.prev_z, corner_ch.next_x, corner_ch.next_y,
         corner_ch.next_z, corner_ch.last_corner} = '0;
        shade_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_AMBIENT;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset values, a plain corner, a zero normal
        add_corner(16'sh0100, 0, 0, 0, 0, 0, 0, 16'sh0100, 0, 1'b1);
        add_corner(16'sh0100, 16'sh0100, 0, 16'sh0100, 16'sh0100, 0,
                   16'sh0100, 16'sh0100, 0, 1'b1);
        drain();

        write_reg(CFG_AMBIENT, 48'd100);
        write_reg(CFG_DIFFUSE, 48'd65535);
        write_reg(CFG_SPECULAR, 48'd65535);
        write_reg(CFG_SPREAD, 48'd0);          // zero exponent counts as one
        write_reg(CFG_VIEW, {16'h0000, 16'h0000, 16'h7FFF});
        write_reg(CFG_LIGHT, {16'h7FFF, 16'h0000, 16'h0000});
        // Extremes of every coordinate, a zero normal, normals facing both ways
        add_corner(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF,
                   -16'sh8000, 16'sh7FFF, -16'sh8000, 1'b0);
        add_corner(-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000,
                   16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b1);
        add_corner(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        add_corner(0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0, 1'b1);
        add_corner(0, 0, 0, 0, 16'sh0100, 0, 16'sh0100, 0, 0, 1'b1);
        add_corner(16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF, 1'b1);
        drain();

        write_reg(CFG_AMBIENT, 48'd65535);
        write_reg(CFG_SPREAD, 48'd65535);
        write_reg(CFG_VIEW, {16'h5A82, 16'h0000, 16'h5A82});
        write_reg(CFG_LIGHT, {16'h8000, 16'h8000, 16'h8000});
        add_corner(0, 0, 16'sh0100, 16'sh0100, 0, 0, 0, 16'sh0100, 0, 1'b1);
        add_corner(0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0, 1'b1);
        drain();

        write_reg(CFG_AMBIENT, 48'd0);
        write_reg(CFG_DIFFUSE, 48'd0);
        write_reg(CFG_SPREAD, 48'd256);
        write_reg(CFG_LIGHT, {16'h5A82, 16'h0000, 16'h5A82});
        // Long group of large cross products: sums grow large
        for (int k = 0; k < 140; k++)
            add_corner(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF,
                       16'sh7FFF, -16'sh8000, 16'sh7FFF, k == 139);
        // Missing last mark: the next vertex picks up the leftover sum
        add_group(3, 2000, 1'b0);
        add_group(2, 2000, 1'b1);
        drain();

        // Random phases with varied settings
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 4))
                0: sp = 16'd0;
                1: sp = 16'd65535;
                2: sp = 16'd256;
                default: sp = $urandom_range(1, 4096);
            endcase
            write_reg(CFG_AMBIENT, ph == 5 ? 48'd0 : 48'($urandom_range(0, 65535)));
            write_reg(CFG_DIFFUSE, 48'($urandom_range(0, 65535)));
            write_reg(CFG_SPECULAR, 48'($urandom_range(0, 65535)));
            write_reg(CFG_SPREAD, 48'(sp));
            write_reg(CFG_VIEW, rand_dir());
            write_reg(CFG_LIGHT, rand_dir());
            if (ph == 5) calm = 1;
            while (corner_q.size() < 170) begin
                case ($urandom_range(0, 9))
                    0: reach = 32767;
                    1: reach = 16;
                    default: reach = $urandom_range(64, 4000);
                endcase
                if ($urandom_range(0, 19) == 0)
                    add_group($urandom_range(1, 4), reach, 1'b0);
                else
                    add_group($urandom_range(1, 6), reach, 1'b1);
            end
            if (ph == 2) hold_due = 1;
            drain();
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/vnps_pkg.sv
hw/rtl/vnps_if.sv
hw/rtl/vnps_iter.sv
hw/rtl/vertex_normal_phong_shader_top.sv
hw/rtl/vnps_check.sv
verif/vertex_normal_phong_shader_top_test.sv
